[sv/sbc_pkg.sv]
// sbc_pkg: shared types, widths, register map and reset values for the
// spinlock backoff controller. No dependencies.
package sbc_pkg;

    localparam int RANDOM_W    = 31;
    localparam int SPIN_W      = 10;
    localparam int DCNT_W      = 16;
    localparam int DELAY_W     = 10;
    localparam int GUARD_W     = 12;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        ACT_ACQUIRED = 2'd0,
        ACT_SPIN     = 2'd1,
        ACT_SLEEP    = 2'd2,
        ACT_STUCK    = 2'd3
    } action_t;

    localparam logic [1:0] REG_SPIN_LIMIT  = 2'd0;
    localparam logic [1:0] REG_DELAY_LIMIT = 2'd1;
    localparam logic [1:0] REG_MIN_DELAY   = 2'd2;
    localparam logic [1:0] REG_MAX_DELAY   = 2'd3;

    localparam logic [SPIN_W-1:0]  SPIN_LIMIT_RST  = 10'd100;
    localparam logic [DCNT_W-1:0]  DELAY_LIMIT_RST = 16'd1000;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RST   = 10'd1;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST   = 10'd100;

    typedef struct packed {
        logic [SPIN_W-1:0]  spin_limit;
        logic [DCNT_W-1:0]  delay_limit;
        logic [DELAY_W-1:0] min_delay;
        logic [DELAY_W-1:0] max_delay;
    } cfg_t;

endpackage

[sv/sbc_in_if.sv]
// sbc_in_if: valid/ready channel carrying one lock attempt word
// depends on sbc_pkg
interface sbc_in_if;
    import sbc_pkg::*;

    logic                valid;
    logic                ready;
    logic                lock_busy;
    logic [RANDOM_W-1:0] random_value;

    modport source (output valid, output lock_busy, output random_value, input ready);
    modport sink (input valid, input lock_busy, input random_value, output ready);
endinterface

[sv/sbc_out_if.sv]
// sbc_out_if: valid/ready channel carrying one backoff decision word
// depends on sbc_pkg
interface sbc_out_if;
    import sbc_pkg::*;

    logic               valid;
    logic               ready;
    action_t            action;
    logic [DELAY_W-1:0] delay_csec;

    modport source (output valid, output action, output delay_csec, input ready);
    modport sink (input valid, input action, input delay_csec, output ready);
endinterface

[sv/sbc_cfg.sv]
// sbc_cfg: APB-style configuration register file (four limits)
// depends on sbc_pkg
module sbc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sbc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output sbc_pkg::cfg_t                    cfg
);
    import sbc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SPIN_LIMIT:  cfg_next.spin_limit  = pwdata[SPIN_W-1:0];
                REG_DELAY_LIMIT: cfg_next.delay_limit = pwdata[DCNT_W-1:0];
                REG_MIN_DELAY:   cfg_next.min_delay   = pwdata[DELAY_W-1:0];
                REG_MAX_DELAY:   cfg_next.max_delay   = pwdata[DELAY_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SPIN_LIMIT:  prdata = CFG_DATA_W'(cfg_reg.spin_limit);
            REG_DELAY_LIMIT: prdata = CFG_DATA_W'(cfg_reg.delay_limit);
            REG_MIN_DELAY:   prdata = CFG_DATA_W'(cfg_reg.min_delay);
            REG_MAX_DELAY:   prdata = CFG_DATA_W'(cfg_reg.max_delay);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spin_limit  <= SPIN_LIMIT_RST;
            cfg_reg.delay_limit <= DELAY_LIMIT_RST;
            cfg_reg.min_delay   <= MIN_DELAY_RST;
            cfg_reg.max_delay   <= MAX_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/sbc_scale.sv]
// sbc_scale: two-stage pipeline turning the random word into a fixed-point
// fraction frac ~ r/RANDOM_MAX (rounded up); depends on sbc_pkg, sbc_in_if
module sbc_scale #(
    parameter int unsigned RANDOM_MAX = 32'd2147483647,
    parameter int          FRAC_W     = 43
) (
    input  logic        clk,
    input  logic        rst_n,
    sbc_in_if.sink      attempt,
    output logic        frac_valid,
    input  logic        frac_ready,
    output logic        frac_busy,
    output logic [FRAC_W:0] frac
);
    import sbc_pkg::*;

    localparam int RAND_BITS = $clog2(RANDOM_MAX + 32'd1);
    localparam int TW        = FRAC_W + 1;
    localparam int MW        = FRAC_W + 2;
    localparam int ML        = MW / 2;
    localparam int MH        = MW - ML;
    localparam int LOW_W     = RAND_BITS + ML;
    localparam int HIGH_W    = RAND_BITS + MH;
    localparam int SUM_W     = RAND_BITS + MW;
    localparam int EW        = FRAC_W + RAND_BITS + 1;

    // reciprocal of RANDOM_MAX, one above the floor so the product never undershoots
    localparam logic [EW-1:0] RECIP_FULL =
        ((EW'(1) << (FRAC_W + RAND_BITS)) / EW'(RANDOM_MAX)) + EW'(1);
    localparam logic [MW-1:0] RECIP    = RECIP_FULL[MW-1:0];
    localparam logic [ML-1:0] RECIP_LO = RECIP[ML-1:0];
    localparam logic [MH-1:0] RECIP_HI = RECIP[MW-1:ML];
    localparam logic [RANDOM_W-1:0] R_MAX = RANDOM_W'(RANDOM_MAX);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_busy_reg;
    logic [LOW_W-1:0]     pp_lo_reg;
    logic [LOW_W-1:0]     pp_lo_next;
    logic [HIGH_W-1:0]    pp_hi_reg;
    logic [HIGH_W-1:0]    pp_hi_next;
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic                 s2_busy_reg;
    logic [TW-1:0]        frac_reg;
    logic [TW-1:0]        frac_next;

    logic                 in_ready;
    logic                 s2_ready;
    logic [RANDOM_W-1:0]  r_sat;
    logic [RAND_BITS-1:0] r_bits;
    logic [SUM_W-1:0]     prod;
    logic [MW-1:0]        quot;

    assign s2_ready      = !s2_valid_reg || frac_ready;
    assign in_ready      = !s1_valid_reg || s2_ready;
    assign attempt.ready = in_ready;

    // saturate words above the random range
    assign r_sat  = (attempt.random_value > R_MAX) ? R_MAX : attempt.random_value;
    assign r_bits = r_sat[RAND_BITS-1:0];

    assign pp_lo_next = LOW_W'(r_bits) * LOW_W'(RECIP_LO);
    assign pp_hi_next = HIGH_W'(r_bits) * HIGH_W'(RECIP_HI);

    assign prod      = (SUM_W'(pp_hi_reg) << ML) + SUM_W'(pp_lo_reg);
    assign quot      = prod[SUM_W-1:RAND_BITS];
    assign frac_next = quot[TW-1:0] + TW'(1);

    assign s1_valid_next = in_ready ? attempt.valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (attempt.valid && in_ready)
        begin
            s1_busy_reg <= attempt.lock_busy;
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_busy_reg <= s1_busy_reg;
            frac_reg    <= frac_next;
        end
    end

    assign frac_valid = s2_valid_reg;
    assign frac_busy  = s2_busy_reg;
    assign frac       = frac_reg;

endmodule

[sv/sbc_ctrl.sv]
// sbc_ctrl: spin/delay counters, delay growth and the result register
// depends on sbc_pkg, sbc_out_if
module sbc_ctrl #(
    parameter int FRAC_W = 43
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sbc_pkg::cfg_t   cfg,
    input  logic            frac_valid,
    output logic            frac_ready,
    input  logic            frac_busy,
    input  logic [FRAC_W:0] frac,
    sbc_out_if.source       result
);
    import sbc_pkg::*;

    localparam int TW = FRAC_W + 1;
    localparam int PW = DELAY_W + TW;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_W - 1);

    logic [SPIN_W-1:0]  spin_cnt_reg;
    logic [SPIN_W-1:0]  spin_cnt_next;
    logic [DCNT_W-1:0]  delay_cnt_reg;
    logic [DCNT_W-1:0]  delay_cnt_next;
    logic [DELAY_W-1:0] delay_now_reg;
    logic [DELAY_W-1:0] delay_now_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    action_t            act_reg;
    action_t            act_next;
    logic [DELAY_W-1:0] dly_reg;
    logic [DELAY_W-1:0] dly_next;

    logic               take;
    logic [PW-1:0]      growth_prod;
    logic [PW-1:0]      grow_sum;
    logic [DELAY_W-1:0] grow;
    logic [DELAY_W:0]   grown;

    assign frac_ready = !out_valid_reg || result.ready;
    assign take       = frac_valid && frac_ready;

    // round(d*r/RANDOM_MAX): frac is never below the true ratio and the guard bits
    // keep its excess under half an lsb of the exact rounding point
    assign growth_prod = PW'(delay_now_reg) * PW'(frac);
    assign grow_sum    = growth_prod + HALF;
    assign grow        = grow_sum[FRAC_W+DELAY_W-1:FRAC_W];
    assign grown       = {1'b0, delay_now_reg} + {1'b0, grow};

    always_comb
    begin
        spin_cnt_next  = spin_cnt_reg;
        delay_cnt_next = delay_cnt_reg;
        delay_now_next = delay_now_reg;
        act_next       = ACT_ACQUIRED;
        dly_next       = '0;
        if (take)
        begin
            priority if (!frac_busy)
            begin
                act_next       = ACT_ACQUIRED;
                spin_cnt_next  = '0;
                delay_cnt_next = '0;
                delay_now_next = cfg.min_delay;
            end
            else if (spin_cnt_reg < cfg.spin_limit)
            begin
                act_next      = ACT_SPIN;
                spin_cnt_next = spin_cnt_reg + SPIN_W'(1);
            end
            else if (delay_cnt_reg >= cfg.delay_limit)
            begin
                act_next       = ACT_STUCK;
                spin_cnt_next  = '0;
                delay_cnt_next = '0;
                delay_now_next = cfg.min_delay;
            end
            else
            begin
                act_next       = ACT_SLEEP;
                dly_next       = delay_now_reg;
                spin_cnt_next  = '0;
                delay_cnt_next = delay_cnt_reg + DCNT_W'(1);
                if (grown > {1'b0, cfg.max_delay})
                begin
                    delay_now_next = cfg.min_delay;
                end
                else
                begin
                    delay_now_next = grown[DELAY_W-1:0];
                end
            end
        end
    end

    assign out_valid_next = take || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_cnt_reg  <= '0;
            delay_cnt_reg <= '0;
            delay_now_reg <= MIN_DELAY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            spin_cnt_reg  <= spin_cnt_next;
            delay_cnt_reg <= delay_cnt_next;
            delay_now_reg <= delay_now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg <= act_next;
            dly_reg <= dly_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.action     = act_reg;
    assign result.delay_csec = dly_reg;

    a_spin_inc: assert property (@(posedge clk) disable iff (!rst_n)
        take && act_next == ACT_SPIN |=> spin_cnt_reg == $past(spin_cnt_reg) + SPIN_W'(1))
        else $error("spin count did not advance on a spin");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && (act_next == ACT_ACQUIRED || act_next == ACT_STUCK)
        |=> spin_cnt_reg == '0 && delay_cnt_reg == '0)
        else $error("counters not cleared on acquire or stuck");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(delay_now_reg) && $stable(delay_cnt_reg) && $stable(spin_cnt_reg))
        else $error("backoff state moved without a word");

    a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.action != ACT_SLEEP |-> result.delay_csec == '0)
        else $error("nonzero delay on a non-sleep word");

endmodule

[sv/spinlock_backoff_controller_core.sv]
// spinlock_backoff_controller_core: top level of the backoff controller
// depends on sbc_pkg, sbc_in_if, sbc_out_if, sbc_cfg, sbc_scale, sbc_ctrl
//
//  channel   dir   handshake      payload
//  -------   ---   ---------      -------
//  attempt   in    valid/ready    lock_busy, random_value[30:0]
//  result    out   valid/ready    action[1:0], delay_csec[9:0]
//  apb       in    psel/penable   paddr[3:0], pwdata/prdata[31:0], pready tied high
//
//  one word per cycle sustained while the result side stays ready; a result
//  passes the two scaling stages, then the state update into the result reg
//  the rate is set by the combinational counter/delay update, whose critical
//  path is the 10-bit delay times fraction multiply plus the wrap compare
//  reset (rst_n, async low) loads the register defaults and sets the current
//  delay to 1; no clearing pass, words are taken straight after reset
//  each stage holds only while its successor is full and stalled, so empty
//  stages keep taking words while a result waits on the output
module spinlock_backoff_controller_core #(
    parameter int unsigned RANDOM_MAX = 32'd2147483647
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sbc_in_if.sink                           attempt,
    sbc_out_if.source                        result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sbc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import sbc_pkg::*;

    // fraction bits: random range plus guard bits so that a 10-bit delay
    // times the rounded-up fraction still rounds like the exact quotient
    localparam int RAND_BITS = $clog2(RANDOM_MAX + 32'd1);
    localparam int FRAC_W    = RAND_BITS + GUARD_W;

    cfg_t            cfg;
    logic            frac_valid;
    logic            frac_ready;
    logic            frac_busy;
    logic [FRAC_W:0] frac;

    // configuration registers
    sbc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // random word to fixed-point fraction, independent of backoff state
    sbc_scale #(
        .RANDOM_MAX (RANDOM_MAX),
        .FRAC_W     (FRAC_W)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .attempt    (attempt),
        .frac_valid (frac_valid),
        .frac_ready (frac_ready),
        .frac_busy  (frac_busy),
        .frac       (frac)
    );

    // counters, delay growth and the output register
    sbc_ctrl #(
        .FRAC_W (FRAC_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .frac_valid (frac_valid),
        .frac_ready (frac_ready),
        .frac_busy  (frac_busy),
        .frac       (frac),
        .result     (result)
    );

endmodule

[tb/sbc_backoff_checker.sv]
// sbc_backoff_checker: watches the attempt, result and apb ports, predicts each decision
// depends on sbc_pkg, sbc_in_if, sbc_out_if
module sbc_backoff_checker #(
    parameter longint unsigned RANDOM_MAX = 64'd2147483647
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sbc_in_if                              attempt,
    sbc_out_if                             result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sbc_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             errors,
    output int                             pending,
    output int                             n_acquired,
    output int                             n_spin,
    output int                             n_sleep,
    output int                             n_stuck
);
    import sbc_pkg::*;

    typedef struct packed {
        action_t            action;
        logic [DELAY_W-1:0] delay_csec;
    } decision_t;

    decision_t decisions_due[$];

    // shadow of the register file
    logic [SPIN_W-1:0]  spin_limit;
    logic [DCNT_W-1:0]  delay_limit;
    logic [DELAY_W-1:0] min_delay;
    logic [DELAY_W-1:0] max_delay;

    // shadow of the backoff state
    logic [SPIN_W-1:0]  spin_count;
    logic [DCNT_W-1:0]  delay_count;
    logic [DELAY_W-1:0] delay_now;

    task automatic report_mismatch(input string what);
        $display("[%0t] decision mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic void restart_backoff();
        spin_count  = '0;
        delay_count = '0;
        delay_now   = min_delay;
    endfunction

    // one attempt in, one decision out; updates the shadow state
    function automatic decision_t next_decision(input logic busy,
                                                input logic [RANDOM_W-1:0] rnd);
        decision_t       d;
        longint unsigned r;
        longint unsigned cur;
        longint unsigned grow;
        longint unsigned nxt;
        r            = rnd;
        d.action     = ACT_ACQUIRED;
        d.delay_csec = '0;
        if (r > RANDOM_MAX)
            r = RANDOM_MAX;
        if (!busy)
        begin
            restart_backoff();
        end
        else if (spin_count < spin_limit)
        begin
            d.action   = ACT_SPIN;
            spin_count = spin_count + 1'b1;
        end
        else if (delay_count >= delay_limit)
        begin
            d.action = ACT_STUCK;
            restart_backoff();
        end
        else
        begin
            // growth is cur*r/RANDOM_MAX rounded half up, exact
            cur          = delay_now;
            grow         = (2 * cur * r + RANDOM_MAX) / (2 * RANDOM_MAX);
            nxt          = cur + grow;
            d.action     = ACT_SLEEP;
            d.delay_csec = delay_now;
            delay_count  = delay_count + 1'b1;
            spin_count   = '0;
            if (nxt > max_delay)
                nxt = min_delay;
            delay_now = nxt[DELAY_W-1:0];
        end
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decision_t exp_d;
        if (!rst_n)
        begin
            spin_limit  = SPIN_LIMIT_RST;
            delay_limit = DELAY_LIMIT_RST;
            min_delay   = MIN_DELAY_RST;
            max_delay   = MAX_DELAY_RST;
            restart_backoff();
            decisions_due.delete();
            errors     = 0;
            n_acquired = 0;
            n_spin     = 0;
            n_sleep    = 0;
            n_stuck    = 0;
            pending   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SPIN_LIMIT:  spin_limit  = pwdata[SPIN_W-1:0];
                    REG_DELAY_LIMIT: delay_limit = pwdata[DCNT_W-1:0];
                    REG_MIN_DELAY:   min_delay   = pwdata[DELAY_W-1:0];
                    REG_MAX_DELAY:   max_delay   = pwdata[DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (decisions_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word action=%0d delay=%0d",
                                              result.action, result.delay_csec));
                end
                else
                begin
                    exp_d = decisions_due.pop_front();
                    if (result.action !== exp_d.action)
                        report_mismatch($sformatf("action got %0d want %0d",
                                                  result.action, exp_d.action));
                    if (result.delay_csec !== exp_d.delay_csec)
                        report_mismatch($sformatf("delay_csec got %0d want %0d",
                                                  result.delay_csec, exp_d.delay_csec));
                    case (exp_d.action)
                        ACT_ACQUIRED: n_acquired++;
                        ACT_SPIN:     n_spin++;
                        ACT_SLEEP:    n_sleep++;
                        default:      n_stuck++;
                    endcase
                end
            end
            if (attempt.valid && attempt.ready)
                decisions_due.push_back(next_decision(attempt.lock_busy,
                                                      attempt.random_value));
            pending <= decisions_due.size();
        end
    end
endmodule

[tb/tb_spinlock_backoff_controller_core.sv]
// tb_spinlock_backoff_controller_core: stimulus and verdict for the backoff controller
// depends on sbc_pkg, sbc_in_if, sbc_out_if, sbc_backoff_checker, spinlock_backoff_controller_core
module tb_spinlock_backoff_controller_core;
    import sbc_pkg::*;

    localparam longint unsigned RMAX = 64'd2147483647;
    // far above the slowest legal run, even with both sides idling
    localparam int unsigned     RUN_LIMIT_CYCLES = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    int n_acquired;
    int n_spin;
    int n_sleep;
    int n_stuck;

    // idling controls, changed per phase
    int send_idle_pct;
    int recv_stall_pct;
    int n_settings;

    sbc_in_if  att_if ();
    sbc_out_if res_if ();

    spinlock_backoff_controller_core #(
        .RANDOM_MAX (32'(RMAX))
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .attempt (att_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // checker sits beside the block and only observes
    sbc_backoff_checker #(
        .RANDOM_MAX (RMAX)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .attempt    (att_if),
        .result     (res_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .errors     (errors),
        .pending    (pending),
        .n_acquired (n_acquired),
        .n_spin     (n_spin),
        .n_sleep    (n_sleep),
        .n_stuck    (n_stuck)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case a word never comes back
    initial
    begin
        #(12 * RUN_LIMIT_CYCLES);
        $display("timeout with %0d decisions outstanding", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // random scaling word, with both ends of the range showing up often
    function automatic logic [RANDOM_W-1:0] draw_scale_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return w[RANDOM_W-1:0];
        endcase
    endfunction

    // offer one attempt word, return at the edge that takes it
    // valid stays high on return so back-to-back words need no second assignment
    task automatic lock_try(input logic busy, input logic [RANDOM_W-1:0] rnd);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            att_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        att_if.valid        <= 1'b1;
        att_if.lock_busy    <= busy;
        att_if.random_value <= rnd;
        do
            @(posedge clk);
        while (!att_if.ready);
    endtask

    // drop valid and wait until every decision has come back
    task automatic drain_decisions();
        att_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // apb write: setup cycle, then access cycle until pready
    // psel is left high so the next write needs no second assignment in one step
    task automatic apb_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // all four registers; only called with nothing in flight
    task automatic program_backoff(input int spin_lim, input int dly_lim,
                                   input int min_d, input int max_d);
        drain_decisions();
        apb_write(REG_SPIN_LIMIT,  spin_lim);
        apb_write(REG_DELAY_LIMIT, dly_lim);
        apb_write(REG_MIN_DELAY,   min_d);
        apb_write(REG_MAX_DELAY,   max_d);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // one random phase: a setting, an idling mode and a mostly-busy stream
    // long busy runs are what gets past spinning into sleep and stuck
    task automatic run_phase(input int spin_lim, input int dly_lim, input int min_d,
                             input int max_d, input int idle_pct, input int stall_pct,
                             input int busy_pct, input int words);
        program_backoff(spin_lim, dly_lim, min_d, max_d);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (words)
            lock_try($urandom_range(0, 99) < busy_pct, draw_scale_word());
    endtask

    initial
    begin
        // every input known from time zero
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        att_if.valid        = 1'b0;
        att_if.lock_busy    = 1'b0;
        att_if.random_value = '0;
        res_if.ready        = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        n_settings          = 1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, acquire and a plain spin
        lock_try(1'b0, '0);
        lock_try(1'b1, '1);
        lock_try(1'b0, '1);

        // directed: tight limits so sleep, growth and stuck show within a few words
        program_backoff(1, 2, 1, 1000);
        lock_try(1'b1, '1);                // spin
        lock_try(1'b1, '1);                // sleep 1, full growth
        lock_try(1'b1, '0);                // spin
        lock_try(1'b1, '1);                // sleep 2, full growth
        lock_try(1'b1, 31'h2AAAAAAA);      // spin
        lock_try(1'b1, 31'h2AAAAAAA);      // delay budget spent: stuck
        lock_try(1'b1, '0);                // spin
        lock_try(1'b1, '0);                // sleep with no growth
        lock_try(1'b1, 31'h40000000);      // spin
        lock_try(1'b1, 31'h40000000);      // sleep, growth near one half
        lock_try(1'b0, 31'h15555555);      // acquire clears everything

        // directed: zero spin and delay limits, every busy word is stuck
        program_backoff(0, 0, 1, 100);
        lock_try(1'b1, '1);
        lock_try(1'b1, '0);
        lock_try(1'b0, '0);

        // directed: zero delay sleeps zero and never grows
        // the min write only lands in the current delay after an acquire, a stuck word or a wrap
        program_backoff(0, 3, 0, 100);
        lock_try(1'b0, '1);
        lock_try(1'b1, '1);
        lock_try(1'b1, '1);
        lock_try(1'b1, '1);
        lock_try(1'b1, '1);

        // directed: max below min wraps after every growth
        program_backoff(0, 4, 500, 10);
        lock_try(1'b0, '0);
        lock_try(1'b1, '1);
        lock_try(1'b1, '0);
        lock_try(1'b1, 31'h12345678);

        // random phases across settings and idling modes
        run_phase(3,   4,     1,    1000, 0,  0,  92, 90);
        run_phase(1,   2,     7,    60,   70, 0,  90, 100);
        run_phase(2,   65535, 1000, 1000, 0,  70, 95, 100);
        run_phase(0,   0,     0,    0,    28, 28, 80, 60);
        run_phase(0,   5,     0,    5,    70, 0,  90, 60);
        run_phase(2,   3,     500,  10,   0,  70, 95, 100);
        run_phase(5,   8,     3,    999,  28, 28, 97, 100);
        run_phase(1,   65535, 1,    1,    0,  0,  96, 90);

        // largest spin and delay limits: an all-busy stream that only spins
        run_phase(1023, 65535, 1, 1000, 0, 0, 100, 40);

        // back to the reset values so those are covered by writes too
        run_phase(100, 1000, 1, 100, 28, 28, 90, 60);

        drain_decisions();
        repeat (4) @(posedge clk);

        $display("run covered %0d register settings and %0d decisions",
                 n_settings, n_acquired + n_spin + n_sleep + n_stuck);
        $display("acquired %0d, spin %0d, sleep %0d, stuck %0d",
                 n_acquired, n_spin, n_sleep, n_stuck);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
